FILE: rtl/hexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hexp_pkg
// Shared types, codes and character helpers for the hex text parser.
// ----------------------------------------------------------------------------
package hexp_pkg;

  localparam int CNT_W = 11;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // register map
  localparam logic REG_MAX_BYTES = 1'b0;
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  // characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] DIGIT_TEN = 8'd10;

  // output buffer
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_AW    = $clog2(OBUF_DEPTH);

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       byte_value;
    logic [CNT_W-1:0] byte_count;
    logic             last;
  } result_t;

  // up to two results per character beat, first one first
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } step_out_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [7:0] t;
    t = 8'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      t = ch - CH_0;
      return {1'b1, t[3:0]};
    end else if (ch >= CH_A_LO && ch <= CH_F_LO) begin
      t = ch - CH_A_LO + DIGIT_TEN;
      return {1'b1, t[3:0]};
    end else if (ch >= CH_A_UP && ch <= CH_F_UP) begin
      t = ch - CH_A_UP + DIGIT_TEN;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic is_skip(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR) || (ch == CH_COMMA);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hexp_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hexp_step
// Parser state and the per-character step logic; up to two results a beat.
// ----------------------------------------------------------------------------
module hexp_step (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire logic [7:0]                 character,
  input  wire logic                       text_end,
  input  wire logic [hexp_pkg::CNT_W-1:0] max_bytes,
  output hexp_pkg::step_out_t             res
);

  logic                       pend;      // one digit held
  logic [3:0]                 nibble;
  logic [hexp_pkg::CNT_W-1:0] count;
  logic                       err;

  logic                       pend_next;
  logic [3:0]                 nibble_next;
  logic [hexp_pkg::CNT_W-1:0] count_next;
  logic                       err_next;

  logic [4:0] dig;
  logic       is_end;
  logic       cap_ok;
  logic [hexp_pkg::CNT_W-1:0] count_inc;

  assign dig       = hexp_pkg::hex_digit(character);
  assign is_end    = text_end || (character == hexp_pkg::CH_NUL);
  assign cap_ok    = count < max_bytes;
  assign count_inc = count + 11'd1;

  always_comb begin
    pend_next   = pend;
    nibble_next = nibble;
    count_next  = count;
    err_next    = err;
    res         = '0;
    if (is_end) begin
      if (!err && pend) begin
        if (cap_ok) begin
          res.v0               = 1'b1;
          res.r0.kind          = hexp_pkg::KIND_DATA;
          res.r0.byte_value    = {4'd0, nibble};
          res.r0.byte_count    = count_inc;
          count_next           = count_inc;
        end else begin
          err_next = 1'b1;
        end
      end
      // status goes in the first free slot
      if (res.v0) begin
        res.v1            = 1'b1;
        res.r1.kind       = err_next ? hexp_pkg::KIND_ERR : hexp_pkg::KIND_OK;
        res.r1.byte_count = count_next;
        res.r1.last       = 1'b1;
      end else begin
        res.v0            = 1'b1;
        res.r0.kind       = err_next ? hexp_pkg::KIND_ERR : hexp_pkg::KIND_OK;
        res.r0.byte_count = count_next;
        res.r0.last       = 1'b1;
      end
      pend_next   = 1'b0;
      nibble_next = 4'd0;
      count_next  = '0;
      err_next    = 1'b0;
    end else if (!err) begin
      if (pend) begin
        pend_next   = 1'b0;
        nibble_next = 4'd0;
        if (dig[4]) begin
          if (cap_ok) begin
            res.v0            = 1'b1;
            res.r0.kind       = hexp_pkg::KIND_DATA;
            res.r0.byte_value = {nibble, dig[3:0]};
            res.r0.byte_count = count_inc;
            count_next        = count_inc;
          end else begin
            err_next = 1'b1;
          end
        end else if (nibble == 4'd0 &&
                     (character == hexp_pkg::CH_X_LO || character == hexp_pkg::CH_X_UP)) begin
          // 0x prefix dropped
        end else begin
          if (cap_ok) begin
            res.v0            = 1'b1;
            res.r0.kind       = hexp_pkg::KIND_DATA;
            res.r0.byte_value = {4'd0, nibble};
            res.r0.byte_count = count_inc;
            count_next        = count_inc;
            // non-hex char judged at token start
            if (!hexp_pkg::is_skip(character)) err_next = 1'b1;
          end else begin
            err_next = 1'b1;
          end
        end
      end else if (dig[4]) begin
        pend_next   = 1'b1;
        nibble_next = dig[3:0];
      end else if (!hexp_pkg::is_skip(character)) begin
        err_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      nibble <= 4'd0;
      count  <= '0;
      err    <= 1'b0;
    end else if (fire) begin
      pend   <= pend_next;
      nibble <= nibble_next;
      count  <= count_next;
      err    <= err_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hexp_obuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hexp_obuf
// Small result queue: takes up to two entries a cycle, gives one when the reader is ready.
// ----------------------------------------------------------------------------
module hexp_obuf (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire hexp_pkg::step_out_t   din,
  output logic                       room2,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output hexp_pkg::result_t          dout
);

  localparam int CW = hexp_pkg::OBUF_AW + 1;

  hexp_pkg::result_t mem [hexp_pkg::OBUF_DEPTH];

  logic [hexp_pkg::OBUF_AW-1:0] wr_ptr;
  logic [hexp_pkg::OBUF_AW-1:0] rd_ptr;
  logic [CW-1:0]                count;

  logic                         w0, w1, pop;
  logic [hexp_pkg::OBUF_AW-1:0] wr_ptr1;
  logic [CW-1:0]                count_next;

  assign w0        = push && din.v0;
  assign w1        = push && din.v0 && din.v1;
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign dout      = mem[rd_ptr];
  assign room2     = count <= CW'(hexp_pkg::OBUF_DEPTH - 2);
  assign wr_ptr1   = wr_ptr + 1'b1;

  always_comb begin
    count_next = count + CW'(w0) + CW'(w1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (w0) mem[wr_ptr] <= din.r0;
    if (w1) mem[wr_ptr1] <= din.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + hexp_pkg::OBUF_AW'(w0) + hexp_pkg::OBUF_AW'(w1);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count <= CW'(hexp_pkg::OBUF_DEPTH - 2))
    else $error("result queue written without room");
`endif

endmodule
`default_nettype wire

FILE: rtl/hex_text_to_bytes_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_text_to_bytes_parser_core
// Streaming hex text parser: characters in, data bytes and a final status out.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | in_valid / in_ready    | character[7:0], text_end
//  output  | out_valid / out_ready  | kind[1:0], byte_value[7:0],
//          |                        | byte_count[10:0], last
//  config  | APB psel/penable/...   | max_bytes at byte address 0
//
//  One character beat a cycle while the queue has room for two entries. A beat
//  is registered in the input stage, then the step logic updates the parser
//  state and writes 0, 1 or 2 results into a 4-entry result queue; results
//  leave from the queue head, so the earliest result is valid in the cycle
//  after its beat passes the step logic.
//  The input stage advances only while the queue has room for two entries, so
//  a stalled output side backs up into in_ready.
//  rst is synchronous: parser state, queue and input stage clear, max_bytes
//  returns to 1024.
// ----------------------------------------------------------------------------
module hex_text_to_bytes_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // character beats
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  character,
  input  wire logic        text_end,
  // result beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       byte_value,
  output logic [10:0]      byte_count,
  output logic             last,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // capacity register
  logic [hexp_pkg::CNT_W-1:0] max_bytes;

  // input stage
  logic       s_valid;
  logic [7:0] s_char;
  logic       s_end;

  logic       adv;      // stage beat goes through the step logic this cycle
  logic       room2;

  hexp_pkg::step_out_t step_res;
  hexp_pkg::result_t   head;

  // ---- register port ------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= hexp_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == hexp_pkg::REG_MAX_BYTES) begin
      max_bytes <= pwdata[hexp_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == hexp_pkg::REG_MAX_BYTES) begin
      prdata = {21'd0, max_bytes};
    end
  end

  // ---- input stage --------------------------------------------------------
  // The stage drains whenever the queue can take a two-result beat, so it
  // refills in the same cycle it empties.
  assign adv      = s_valid && room2;
  assign in_ready = !s_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_char <= character;
      s_end  <= text_end;
    end
  end

  // ---- step logic and parser state ----------------------------------------
  hexp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (adv),
    .character (s_char),
    .text_end  (s_end),
    .max_bytes (max_bytes),
    .res       (step_res)
  );

  // ---- result queue -------------------------------------------------------
  hexp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv),
    .din       (step_res),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (head)
  );

  assign kind       = head.kind;
  assign byte_value = head.byte_value;
  assign byte_count = head.byte_count;
  assign last       = head.last;

`ifndef ASSERT_OFF
  a_data_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == hexp_pkg::KIND_DATA) |-> (byte_count != 11'd0 && !last))
    else $error("data beat with zero count or last set");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != hexp_pkg::KIND_DATA) |-> (last && byte_value == 8'd0))
    else $error("status beat malformed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");
`endif

endmodule
`default_nettype wire
